// ===== hdl/base64_stream_decoder_core_macros.svh =====
// assertion macros shared by the base64 stream decoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define B64D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// expression never holds at a clock edge
`define B64D_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hdl/b64d_pkg.sv =====
// package for the base64 stream decoder: status codes, job type, alphabet lookup
// no dependencies
package b64d_pkg;

  localparam int unsigned CFG_W            = 13;
  localparam int unsigned LEN_W            = 13;
  localparam logic [CFG_W-1:0] MAX_BUFFER_BYTES = 13'd4096;
  localparam logic [CFG_W-1:0] MAX_OUTPUT_RST   = 13'd2048;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [6:0] SYM_BAD  = 7'd64;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PARTIAL = 3'd1,
    ST_BAD     = 3'd2,
    ST_FULL    = 3'd3,
    ST_CR      = 3'd4
  } status_e;

  // one front decision: up to three bytes and an optional closing status
  typedef struct packed {
    logic [2:0][7:0]  data;
    logic [1:0]       nbytes;
    logic [LEN_W-1:0] base;
    logic             has_status;
    status_e          status;
  } job_t;

  // 6-bit alphabet value, SYM_BAD for anything outside the alphabet
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
// front end: message state, group gathering, alphabet and padding checks
// depends on b64d_pkg; emits one job per character that causes results
module b64d_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               char_in_i,
  input  logic                     end_of_message_i,
  input  logic [b64d_pkg::CFG_W-1:0] limit_i,
  output logic                     push_o,
  output b64d_pkg::job_t           job_o
);
  import b64d_pkg::*;

  logic [2:0][7:0]  chars_q, chars_d;
  logic [1:0]       gc_q, gc_d;
  logic             pad_q, pad_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             start_q, start_d;
  logic             disc_q, disc_d;

  logic [6:0]  v0, v1, v2, v3;
  logic        eq2, eq3, bad;
  logic [1:0]  nb, n_emit;
  logic        full;
  logic [LEN_W:0] c1, c2, c3, lim_x;
  logic        new_msg;

  always_comb begin
    v0    = sym_value(chars_q[0]);
    v1    = sym_value(chars_q[1]);
    v2    = sym_value(chars_q[2]);
    v3    = sym_value(char_in_i);
    eq2   = (chars_q[2] == CHAR_PAD);
    eq3   = (char_in_i == CHAR_PAD);
    bad   = (v0 == SYM_BAD) || (v1 == SYM_BAD) || (!eq2 && v2 == SYM_BAD) ||
            (!eq3 && v3 == SYM_BAD) || (eq2 && !eq3);
    nb    = eq2 ? 2'd1 : (eq3 ? 2'd2 : 2'd3);
    lim_x = {1'b0, limit_i};
    c1    = {1'b0, count_q} + 14'd1;
    c2    = {1'b0, count_q} + 14'd2;
    c3    = {1'b0, count_q} + 14'd3;
    // stop at the first byte that reaches the limit
    if (c1 >= lim_x) begin
      n_emit = 2'd1;
      full   = 1'b1;
    end else if (nb != 2'd1 && c2 >= lim_x) begin
      n_emit = 2'd2;
      full   = 1'b1;
    end else if (nb == 2'd3 && c3 >= lim_x) begin
      n_emit = 2'd3;
      full   = 1'b1;
    end else begin
      n_emit = nb;
      full   = 1'b0;
    end
  end

  always_comb begin
    chars_d = chars_q;
    gc_d    = gc_q;
    pad_d   = pad_q;
    count_d = count_q;
    start_d = start_q;
    disc_d  = disc_q;
    new_msg = 1'b0;
    push_o  = 1'b0;
    job_o   = '0;
    job_o.base = count_q;
    if (accept_i) begin
      if (disc_q) begin
        new_msg = end_of_message_i;
      end else if (start_q && char_in_i == CHAR_CR) begin
        push_o            = 1'b1;
        job_o.has_status  = 1'b1;
        job_o.status      = ST_CR;
        new_msg           = end_of_message_i;
        disc_d            = !end_of_message_i;
      end else begin
        start_d = 1'b0;
        if (pad_q) begin
          push_o           = 1'b1;
          job_o.has_status = 1'b1;
          job_o.status     = ST_BAD;
          new_msg          = end_of_message_i;
          disc_d           = !end_of_message_i;
        end else if (gc_q != 2'd3) begin
          chars_d[gc_q] = char_in_i;
          gc_d          = gc_q + 2'd1;
          if (end_of_message_i) begin
            push_o           = 1'b1;
            job_o.has_status = 1'b1;
            job_o.status     = ST_PARTIAL;
            new_msg          = 1'b1;
          end
        end else begin
          gc_d   = 2'd0;
          push_o = 1'b1;
          if (bad) begin
            job_o.has_status = 1'b1;
            job_o.status     = ST_BAD;
            new_msg          = end_of_message_i;
            disc_d           = !end_of_message_i;
          end else begin
            pad_d         = eq2 || eq3;
            job_o.data[0] = {v0[5:0], v1[5:4]};
            job_o.data[1] = {v1[3:0], v2[5:2]};
            job_o.data[2] = {v2[1:0], v3[5:0]};
            job_o.nbytes  = n_emit;
            count_d       = count_q + LEN_W'(n_emit);
            if (full) begin
              job_o.has_status = 1'b1;
              job_o.status     = ST_FULL;
              new_msg          = end_of_message_i;
              disc_d           = !end_of_message_i;
            end else if (end_of_message_i) begin
              job_o.has_status = 1'b1;
              job_o.status     = ST_OK;
              new_msg          = 1'b1;
            end
          end
        end
      end
    end
    if (new_msg) begin
      chars_d = '0;
      gc_d    = 2'd0;
      pad_d   = 1'b0;
      count_d = '0;
      start_d = 1'b1;
      disc_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      gc_q    <= 2'd0;
      pad_q   <= 1'b0;
      count_q <= '0;
      start_q <= 1'b1;
      disc_q  <= 1'b0;
    end else begin
      chars_q <= chars_d;
      gc_q    <= gc_d;
      pad_q   <= pad_d;
      count_q <= count_d;
      start_q <= start_d;
      disc_q  <= disc_d;
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
// short job queue between front and back ends
// depends on b64d_pkg and the shared assertion macros
`include "base64_stream_decoder_core_macros.svh"

module b64d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t job_i,
  input  logic           pop_i,
  output b64d_pkg::job_t head_o,
  output logic           nempty_o,
  output logic           full_o
);
  import b64d_pkg::*;

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_CW-1:0] cnt_q;

  assign nempty_o = (cnt_q != '0);
  assign full_o   = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign head_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `B64D_ASSERT_NEVER(a_push_full, push_i && full_o && !pop_i, "job pushed into a full queue")
  `B64D_ASSERT_NEVER(a_pop_empty, pop_i && !nempty_o, "job popped from an empty queue")

endmodule

// ===== hdl/b64d_back.sv =====
// back end: expands jobs to data/status results, one per unstalled cycle
// depends on b64d_pkg and the shared assertion macros
`include "base64_stream_decoder_core_macros.svh"

module b64d_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  b64d_pkg::job_t             head_i,
  input  logic                       nempty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 data_byte_o,
  output logic                       kind_o,
  output logic [2:0]                 status_o,
  output logic [b64d_pkg::LEN_W-1:0] decoded_length_o,
  output logic                       last_o
);
  import b64d_pkg::*;

  logic [1:0]       idx_q;
  logic             valid_q;
  logic [7:0]       data_q;
  logic             kind_q, last_q;
  logic [2:0]       status_q;
  logic [LEN_W-1:0] len_q;

  logic [2:0] total, idx_x;
  logic       advance, load, is_data, idx_ok;

  assign total   = {1'b0, head_i.nbytes} + {2'b00, head_i.has_status};
  assign idx_x   = {1'b0, idx_q};
  assign idx_ok  = (idx_x < total);
  assign advance = !valid_q || !out_stall_i;
  assign load    = advance && nempty_i;
  assign pop_o   = load && (idx_x == total - 3'd1);
  assign is_data = (idx_q < head_i.nbytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (advance) begin
        valid_q <= nempty_i;
      end
      if (pop_o) begin
        idx_q <= 2'd0;
      end else if (load) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_data) begin
        data_q   <= head_i.data[idx_q];
        kind_q   <= 1'b0;
        status_q <= ST_OK;
        len_q    <= head_i.base + LEN_W'(idx_q) + 1'b1;
        last_q   <= 1'b0;
      end else begin
        data_q   <= 8'd0;
        kind_q   <= 1'b1;
        status_q <= head_i.status;
        len_q    <= head_i.base + LEN_W'(head_i.nbytes);
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign data_byte_o      = data_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign decoded_length_o = len_q;
  assign last_o           = last_q;

  `B64D_ASSERT_IMPL(a_status_is_last, valid_q && kind_q, last_q, "status result without last")
  `B64D_ASSERT_IMPL(a_idx_in_job, nempty_i, idx_ok, "result index beyond the job")

endmodule

// ===== hdl/base64_stream_decoder_core.sv =====
// top level of the base64 stream decoder
// depends on b64d_pkg, b64d_front, b64d_queue and b64d_back
//
// streaming base64 decoder: one character is taken per transfer, up to one per
// cycle. groups of four characters are checked against the standard alphabet
// and the '=' padding rules and give one to three data bytes; each message
// closes with one status result (ok, partial group, bad encoding, output full,
// leading carriage return) carrying the decoded length. after an error the
// rest of the message is dropped up to the character flagged as end of message.
// a character is decided in the front end and leaves a job in a two-entry
// queue; the back end turns a job into its results at one result per cycle
// through an output register unless the output stalls. four characters give
// at most four results, so one character per cycle is sustained; the input
// stalls only while the job queue is full, e.g. when the output side stalls.
// a character's first result passes the job queue, then the output register.
// max_output must be written through cfg_we_i only while idle; the block does
// not enforce this. the limit used is the smaller of max_output and 4096 bytes
module base64_stream_decoder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // character input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 char_in_i,
  input  logic                       end_of_message_i,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [b64d_pkg::CFG_W-1:0] cfg_wdata_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 data_byte_o,
  output logic                       kind_o,
  output logic [2:0]                 status_o,
  output logic [b64d_pkg::LEN_W-1:0] decoded_length_o,
  output logic                       last_o
);
  import b64d_pkg::*;

  // configuration register and the clamped limit
  logic [CFG_W-1:0] max_output_q;
  logic [CFG_W-1:0] limit;

  // front/back interconnect
  logic accept, push, pop, nempty, full;
  job_t job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_output_q <= MAX_OUTPUT_RST;
    end else if (cfg_we_i) begin
      max_output_q <= cfg_wdata_i;
    end
  end

  assign limit = (max_output_q > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : max_output_q;

  // input stalls only while there is no room for a job
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  b64d_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .limit_i          (limit),
    .push_o           (push),
    .job_o            (job)
  );

  b64d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .nempty_o (nempty),
    .full_o   (full)
  );

  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .nempty_i         (nempty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .kind_o           (kind_o),
    .status_o         (status_o),
    .decoded_length_o (decoded_length_o),
    .last_o           (last_o)
  );

endmodule
